### rtl/lmc_pkg.sv
`default_nettype none

package lmc_pkg;

  // register map
  localparam int unsigned            REG_COUNT          = 1;
  localparam int unsigned            ADDR_W             = 3;
  localparam logic [ADDR_W-3:0]      REG_EFFECT_CONTROL = 1'b0;

  // effect latch
  localparam logic [7:0]             EFFECT_BLANK       = 8'h30;

  // fixed pens and masks
  localparam logic [2:0]             BULLET_PEN         = 3'd7;
  localparam int unsigned            SPRITE_MARK_BIT    = 3;

  // winning layer codes
  localparam logic [1:0]             LAYER_EFFECT       = 2'd0;
  localparam logic [1:0]             LAYER_TILE         = 2'd1;
  localparam logic [1:0]             LAYER_BULLET       = 2'd2;
  localparam logic [1:0]             LAYER_SPRITE       = 2'd3;

  // collision flag bit positions
  localparam int unsigned            FLAG_S1_BG         = 0;
  localparam int unsigned            FLAG_S3_BG         = 1;
  localparam int unsigned            FLAG_BULLET_S1     = 2;
  localparam int unsigned            FLAG_BULLET_S3     = 3;

  // one pixel request
  typedef struct packed {
    logic [7:0] effect_code;
    logic [2:0] tile_pen;
    logic [7:0] sprite_one_pixel;
    logic [7:0] sprite_two_pixel;
    logic [7:0] sprite_three_pixel;
    logic       background_marked;
    logic       bullet_here;
    logic       clear_flags;
  } lmc_in_t;

  // one mixed pixel
  typedef struct packed {
    logic [9:0] pen_index;
    logic [1:0] winning_layer;
    logic [3:0] collision_flags;
  } lmc_out_t;

endpackage

`default_nettype wire

### rtl/lmc_cfg.sv
`default_nettype none

module lmc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lmc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [7:0]                 effect_control
);
  import lmc_pkg::*;

  logic [ADDR_W-3:0] reg_index;
  logic              wr_en;

  // word index from byte address
  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // effect latch
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_control <= EFFECT_BLANK;
    end else if (wr_en && (reg_index == REG_EFFECT_CONTROL)) begin
      effect_control <= pwdata[7:0];
    end
  end

  // read mux
  always_comb begin
    prdata = 32'h0;
    case (reg_index)
      REG_EFFECT_CONTROL: prdata = {24'h0, effect_control};
      default:            prdata = 32'h0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/lmc_mix.sv
`default_nettype none

module lmc_mix (
  input  wire logic             [7:0] effect_control,
  input  wire lmc_pkg::lmc_in_t       pix,
  input  wire logic             [3:0] flags,
  output lmc_pkg::lmc_out_t           mixed
);
  import lmc_pkg::*;

  logic [7:0] spr;
  logic       spr_on;
  logic [9:0] effect_pen;
  logic [3:0] flags_base;
  logic [3:0] hits;

  // combined sprite pixel
  assign spr    = pix.sprite_one_pixel | pix.sprite_two_pixel | pix.sprite_three_pixel;
  assign spr_on = (spr != 8'h0);

  // effect bank is the inverted intensity bits
  assign effect_pen = (effect_control == EFFECT_BLANK) ? 10'h0
                    : {~effect_control[5:4], pix.effect_code};

  // layer priority, back to front, and the updated flags
  always_comb begin
    mixed.pen_index       = effect_pen;
    mixed.winning_layer   = LAYER_EFFECT;
    mixed.collision_flags = flags_base | hits;
    if (pix.tile_pen != 3'h0) begin
      mixed.pen_index     = {7'h0, pix.tile_pen};
      mixed.winning_layer = LAYER_TILE;
    end
    if (pix.bullet_here) begin
      mixed.pen_index     = {7'h0, BULLET_PEN};
      mixed.winning_layer = LAYER_BULLET;
    end
    if (spr_on) begin
      mixed.pen_index     = {6'h0, spr[3:0]};
      mixed.winning_layer = LAYER_SPRITE;
    end
  end

  // collision hits on this pixel, clear acts first
  always_comb begin
    hits                 = 4'h0;
    hits[FLAG_BULLET_S1] = pix.bullet_here && (pix.sprite_one_pixel != 8'h0);
    hits[FLAG_BULLET_S3] = pix.bullet_here && (pix.sprite_three_pixel != 8'h0);
    hits[FLAG_S1_BG]     = spr_on && pix.background_marked
                           && pix.sprite_one_pixel[SPRITE_MARK_BIT];
    hits[FLAG_S3_BG]     = spr_on && pix.background_marked
                           && pix.sprite_three_pixel[SPRITE_MARK_BIT];
  end

  assign flags_base = pix.clear_flags ? 4'h0 : flags;

endmodule

`default_nettype wire

### rtl/layer_mixer_with_collision_top.sv
`default_nettype none

// Pixel layer mixer with sticky collision flags.
// Input channel pix/pix_valid/pix_ready carries one pixel request: effect
// byte, tile pen, three sprite pixels, background mark, bullet and clear.
// Output channel res/res_valid/res_ready returns one result per request:
// final pen, winning layer and the collision flags after that pixel.
// The effect latch sits on the APB port at byte address 0; pready is
// always high and a write lands at the access cycle.
// After a request is accepted it lands in the input register, and the mixing
// logic fills the result register from it once that register is empty or being
// drained. One request is taken every cycle while the output is drained;
// the rate is set by the single pass from input to result register.
// A stalled receiver holds the result register; the input register still
// takes one more request, then pix_ready drops until the result moves.
// Synchronous reset empties both registers, clears the collision flags
// and loads the effect latch with the blanking value.
module layer_mixer_with_collision_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pix_valid,
  output logic                            pix_ready,
  input  wire lmc_pkg::lmc_in_t           pix,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output lmc_pkg::lmc_out_t               res,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lmc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import lmc_pkg::*;

  logic       [7:0] effect_control;
  logic             st_valid;
  lmc_in_t          st;
  logic       [3:0] flags;
  lmc_out_t         mixed;
  logic             advance;

  // register port
  lmc_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .effect_control (effect_control)
  );

  // mixing logic
  lmc_mix u_mix (
    .effect_control (effect_control),
    .pix            (st),
    .flags          (flags),
    .mixed          (mixed)
  );

  // pipeline flow control
  assign advance   = st_valid && (!res_valid || res_ready);
  assign pix_ready = !st_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (pix_ready) begin
      st_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      st <= pix;
    end
  end

  // result register and sticky flags
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      flags     <= 4'h0;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
        flags     <= mixed.collision_flags;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= mixed;
    end
  end

  // reset leaves flags clear and both stages empty
  assert property (@(posedge clk) rst |=> (flags == 4'h0) && !res_valid && !st_valid)
    else $error("reset did not empty pipeline");

  // flags never drop without a clear
  assert property (@(posedge clk) disable iff (rst)
    advance && !st.clear_flags |=> ((flags & $past(flags)) == $past(flags)))
    else $error("sticky flag lost");

  // clear with nothing to hit leaves flags empty
  assert property (@(posedge clk) disable iff (rst)
    advance && st.clear_flags && !st.bullet_here && !st.background_marked
    |=> (res.collision_flags == 4'h0))
    else $error("clear not applied");

  // result flags track the flag register
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.collision_flags == flags))
    else $error("result flags out of step");

  // sprite and bullet pens stay in the low range
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.winning_layer == LAYER_SPRITE || res.winning_layer == LAYER_BULLET)
    |-> (res.pen_index[9:4] == 6'h0))
    else $error("sprite or bullet pen out of range");

endmodule

`default_nettype wire
